[sv/scpi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCPI command line parser package
// Shared sizes, phase and result codes, and the transaction types that pass
// between the character classifier, the parse engine and the result queue.
// ----------------------------------------------------------------------------
package scpi_pkg;

   localparam int FIELD_MAX    = 64;
   localparam int CHANNEL_BITS = 8;
   localparam int CNT_W        = $clog2(FIELD_MAX + 1);
   localparam int CHW          = CHANNEL_BITS + 5;

   localparam logic [3:0] PH_BEGIN   = 4'd0;
   localparam logic [3:0] PH_CH_ZERO = 4'd1;
   localparam logic [3:0] PH_CH_X    = 4'd2;
   localparam logic [3:0] PH_CH_HEX  = 4'd3;
   localparam logic [3:0] PH_CH_OCT  = 4'd4;
   localparam logic [3:0] PH_CH_DEC  = 4'd5;
   localparam logic [3:0] PH_HEADER  = 4'd6;
   localparam logic [3:0] PH_EXT     = 4'd7;
   localparam logic [3:0] PH_GAP     = 4'd8;
   localparam logic [3:0] PH_VALUE   = 4'd9;
   localparam logic [3:0] PH_DONE    = 4'd10;
   localparam logic [3:0] PH_ERROR   = 4'd11;

   localparam logic [1:0] KIND_DROP   = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_EXT    = 2'd2;
   localparam logic [1:0] KIND_VALUE  = 2'd3;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BAD_CHANNEL = 3'd1;
   localparam logic [2:0] ST_BAD_HEADER  = 3'd2;
   localparam logic [2:0] ST_BAD_EXT     = 3'd3;
   localparam logic [2:0] ST_EMPTY       = 3'd4;
   localparam logic [2:0] ST_OVERFLOW    = 3'd5;

   localparam logic [1:0] REQ_NONE  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       is_ws;
      logic       is_digit;
      logic       is_alnum;
      logic       is_colon;
      logic       is_dot;
      logic       is_query;
      logic       is_x;
      logic       is_zero;
      logic       hex_ok;
      logic [3:0] hex_val;
   } char_class_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] ch;
      logic [5:0] index;
      logic       done;
      logic [2:0] status;
      logic [1:0] request;
      logic [7:0] channel;
      logic       given;
   } result_type;

endpackage

[sv/scpi_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCPI character classifier
// Accepts one character per transaction, classifies it and holds it in a
// two-entry queue until the parse engine takes it.
// ----------------------------------------------------------------------------
module scpi_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [7:0]              req_in_char,
   input  logic                    req_last_char,
   output logic                    q_valid,
   output scpi_pkg::char_class_type q_item,
   input  logic                    q_take
);
   import scpi_pkg::*;

   char_class_type cls;
   char_class_type slot_ff [2];
   logic [1:0]     count_ff, count_in;
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic           push_ok;
   logic           is_upper, is_lower;

   always_comb begin
      is_upper     = (req_in_char >= 8'h41) && (req_in_char <= 8'h5A);
      is_lower     = (req_in_char >= 8'h61) && (req_in_char <= 8'h7A);
      cls.ch       = req_in_char;
      cls.last     = req_last_char;
      cls.is_ws    = (req_in_char == 8'h20) || ((req_in_char >= 8'h09) && (req_in_char <= 8'h0D));
      cls.is_digit = (req_in_char >= 8'h30) && (req_in_char <= 8'h39);
      cls.is_alnum = cls.is_digit || is_upper || is_lower;
      cls.is_colon = (req_in_char == 8'h3A);
      cls.is_dot   = (req_in_char == 8'h2E);
      cls.is_query = (req_in_char == 8'h3F);
      cls.is_x     = (req_in_char == 8'h78) || (req_in_char == 8'h58);
      cls.is_zero  = (req_in_char == 8'h30);
      cls.hex_ok   = 1'b1;
      cls.hex_val  = 4'd0;
      if (cls.is_digit) begin
         cls.hex_val = 4'(req_in_char - 8'h30);
      end else if ((req_in_char >= 8'h61) && (req_in_char <= 8'h66)) begin
         cls.hex_val = 4'(req_in_char - 8'h57);
      end else if ((req_in_char >= 8'h41) && (req_in_char <= 8'h46)) begin
         cls.hex_val = 4'(req_in_char - 8'h37);
      end else begin
         cls.hex_ok = 1'b0;
      end
   end

   assign req_full = (count_ff == 2'd2);
   assign push_ok  = req_push && !req_full;
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_ok) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (q_take) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push_ok && !q_take) begin
         count_in = count_ff + 2'd1;
      end else if (!push_ok && q_take) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

[sv/scpi_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCPI parse engine
// Runs the line parser one classified character per cycle while the result
// queue has room, producing one result transaction per character.
// ----------------------------------------------------------------------------
module scpi_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  scpi_pkg::char_class_type q_item,
   output logic                     q_take,
   input  logic                     out_full,
   output logic                     out_push,
   output scpi_pkg::result_type     out_result
);
   import scpi_pkg::*;

   localparam logic [1:0] BASE8  = 2'd0;
   localparam logic [1:0] BASE10 = 2'd1;
   localparam logic [1:0] BASE16 = 2'd2;
   localparam logic [CHANNEL_BITS-1:0] CHAN_TOP = '1;

   logic [3:0]              phase_ff, phase_in;
   logic [CHANNEL_BITS-1:0] chan_ff, chan_in;
   logic                    seen_ff, seen_in;
   logic [1:0]              req_ff, req_in;
   logic [2:0]              err_ff, err_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;

   logic [CHW-1:0]          ext, dig, sum8, sum10, sum16;
   logic [CHANNEL_BITS-1:0] sat8, sat10, sat16;
   logic                    do_header, do_place, dig_go, dig_ok;
   logic [1:0]              dig_base, place_kind, kind;
   logic [CNT_W-1:0]        idx;
   logic [2:0]              st;

   function automatic logic [CHANNEL_BITS-1:0] sat(input logic [CHW-1:0] v);
      if (v > CHW'(CHAN_TOP)) begin
         return CHAN_TOP;
      end
      return v[CHANNEL_BITS-1:0];
   endfunction

   assign ext   = CHW'(chan_ff);
   assign dig   = CHW'(q_item.hex_val);
   assign sum8  = (ext << 3) + dig;
   assign sum10 = (ext << 3) + (ext << 1) + dig;
   assign sum16 = (ext << 4) + dig;
   assign sat8  = sat(sum8);
   assign sat10 = sat(sum10);
   assign sat16 = sat(sum16);

   assign q_take   = q_valid && !out_full;
   assign out_push = q_take;

   always_comb begin
      phase_in   = phase_ff;
      chan_in    = chan_ff;
      seen_in    = seen_ff;
      req_in     = req_ff;
      err_in     = err_ff;
      cnt_in     = cnt_ff;
      kind       = KIND_DROP;
      idx        = '0;
      do_header  = 1'b0;
      do_place   = 1'b0;
      place_kind = KIND_DROP;
      dig_go     = 1'b0;
      dig_base   = BASE10;
      dig_ok     = 1'b0;
      st         = ST_OK;

      case (phase_ff)
         PH_BEGIN: begin
            if (q_item.is_ws) begin
               phase_in = PH_BEGIN;
            end else if (q_item.is_digit) begin
               seen_in = 1'b1;
               if (q_item.is_zero) begin
                  phase_in = PH_CH_ZERO;
                  chan_in  = '0;
               end else begin
                  // channel is still zero here, so the decimal sum is the digit
                  phase_in = PH_CH_DEC;
                  chan_in  = sat10;
               end
            end else begin
               phase_in  = PH_HEADER;
               cnt_in    = '0;
               do_header = 1'b1;
            end
         end
         PH_CH_ZERO: begin
            if (q_item.is_x) begin
               phase_in = PH_CH_X;
            end else begin
               phase_in = PH_CH_OCT;
               dig_go   = 1'b1;
               dig_base = BASE8;
            end
         end
         PH_CH_X: begin
            if (q_item.hex_ok) begin
               phase_in = PH_CH_HEX;
               chan_in  = sat16;
            end else begin
               err_in   = ST_BAD_CHANNEL;
               phase_in = PH_ERROR;
            end
         end
         PH_CH_HEX: begin
            dig_go   = 1'b1;
            dig_base = BASE16;
         end
         PH_CH_OCT: begin
            dig_go   = 1'b1;
            dig_base = BASE8;
         end
         PH_CH_DEC: begin
            dig_go   = 1'b1;
            dig_base = BASE10;
         end
         PH_HEADER: begin
            do_header = 1'b1;
         end
         PH_EXT: begin
            if (q_item.is_ws) begin
               phase_in = PH_GAP;
               req_in   = REQ_WRITE;
            end else if (q_item.is_alnum) begin
               do_place   = 1'b1;
               place_kind = KIND_EXT;
            end else begin
               err_in   = ST_BAD_EXT;
               phase_in = PH_ERROR;
            end
         end
         PH_GAP: begin
            if (q_item.is_ws) begin
               phase_in = PH_GAP;
            end else if (q_item.is_query) begin
               phase_in = PH_DONE;
               req_in   = REQ_READ;
            end else begin
               phase_in   = PH_VALUE;
               cnt_in     = '0;
               req_in     = REQ_WRITE;
               do_place   = 1'b1;
               place_kind = KIND_VALUE;
            end
         end
         PH_VALUE: begin
            do_place   = 1'b1;
            place_kind = KIND_VALUE;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      if (do_header) begin
         if (q_item.is_dot) begin
            phase_in = PH_EXT;
            cnt_in   = '0;
         end else if (q_item.is_ws) begin
            phase_in = PH_GAP;
            req_in   = REQ_WRITE;
         end else if (q_item.is_alnum || q_item.is_colon) begin
            do_place   = 1'b1;
            place_kind = KIND_HEADER;
         end else if (q_item.is_query) begin
            phase_in = PH_DONE;
            req_in   = REQ_READ;
         end else begin
            err_in   = ST_BAD_HEADER;
            phase_in = PH_ERROR;
         end
      end

      if (dig_go) begin
         case (dig_base)
            BASE8:   dig_ok = q_item.hex_ok && (q_item.hex_val < 4'd8);
            BASE16:  dig_ok = q_item.hex_ok;
            default: dig_ok = q_item.hex_ok && (q_item.hex_val < 4'd10);
         endcase
         if (q_item.is_colon) begin
            phase_in = PH_HEADER;
            cnt_in   = '0;
         end else if (dig_ok) begin
            case (dig_base)
               BASE8:   chan_in = sat8;
               BASE16:  chan_in = sat16;
               default: chan_in = sat10;
            endcase
         end else begin
            err_in   = ST_BAD_CHANNEL;
            phase_in = PH_ERROR;
         end
      end

      if (do_place) begin
         if (cnt_in >= CNT_W'(FIELD_MAX)) begin
            err_in   = ST_OVERFLOW;
            phase_in = PH_ERROR;
         end else begin
            kind   = place_kind;
            idx    = cnt_in;
            cnt_in = cnt_in + CNT_W'(1);
         end
      end

      out_result         = '0;
      out_result.kind    = kind;
      out_result.ch      = q_item.ch;
      out_result.index   = 6'(idx);
      out_result.done    = q_item.last;

      if (q_item.last) begin
         st = err_in;
         if (st == ST_OK) begin
            if (phase_in == PH_BEGIN) begin
               st = ST_EMPTY;
            end else if (phase_in inside {[PH_CH_ZERO:PH_CH_DEC]}) begin
               st = ST_BAD_CHANNEL;
            end
         end
         out_result.status  = st;
         out_result.request = req_in;
         out_result.channel = 8'(chan_in);
         out_result.given   = seen_in;
         // line finished: return to the idle parse state
         phase_in = PH_BEGIN;
         chan_in  = '0;
         seen_in  = 1'b0;
         req_in   = REQ_NONE;
         err_in   = ST_OK;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BEGIN;
         chan_ff  <= '0;
         seen_ff  <= 1'b0;
         req_ff   <= REQ_NONE;
         err_ff   <= ST_OK;
         cnt_ff   <= '0;
      end else if (q_take) begin
         phase_ff <= phase_in;
         chan_ff  <= chan_in;
         seen_ff  <= seen_in;
         req_ff   <= req_in;
         err_ff   <= err_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[sv/scpi_rsp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCPI result queue
// Two-entry queue that holds result transactions until the consumer pops them.
// ----------------------------------------------------------------------------
module scpi_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_push,
   input  scpi_pkg::result_type in_result,
   output logic                 in_full,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [1:0]           rsp_field_kind,
   output logic [7:0]           rsp_out_char,
   output logic [5:0]           rsp_field_index,
   output logic                 rsp_line_done,
   output logic [2:0]           rsp_status,
   output logic [1:0]           rsp_request,
   output logic [7:0]           rsp_channel,
   output logic                 rsp_channel_given
);
   import scpi_pkg::*;

   result_type slot_ff [2];
   result_type head;
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic       push_ok, pop_ok;

   assign in_full   = (count_ff == 2'd2);
   assign rsp_empty = (count_ff == 2'd0);
   assign push_ok   = in_push && !in_full;
   assign pop_ok    = rsp_pop && !rsp_empty;
   assign head      = slot_ff[rd_ptr_ff];

   assign rsp_field_kind    = head.kind;
   assign rsp_out_char      = head.ch;
   assign rsp_field_index   = head.index;
   assign rsp_line_done     = head.done;
   assign rsp_status        = head.status;
   assign rsp_request       = head.request;
   assign rsp_channel       = head.channel;
   assign rsp_channel_given = head.given;

   always_comb begin
      count_in = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 2'd1;
      end else if (!push_ok && pop_ok) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push_ok) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop_ok) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= in_result;
      end
   end

endmodule

[sv/scpi_command_line_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SCPI command line parser
// Streaming parser for one command line, one character per transaction, one
// result transaction per character.
// ----------------------------------------------------------------------------
// Sustains one character per clock cycle while the result side is not stalled.
// An accepted character is held in the input queue, parsed combinationally by
// the parse engine, and its result is registered in the result queue, whose
// head drives the rsp_ ports.
// The rate is set by the parse step, which updates the line state for each
// character; two-entry queues on the input and result sides absorb a short
// stall on either side, which stops the other only once they are full.
module scpi_command_line_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_char,
   input  logic       req_last_char,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_field_kind,
   output logic [7:0] rsp_out_char,
   output logic [5:0] rsp_field_index,
   output logic       rsp_line_done,
   output logic [2:0] rsp_status,
   output logic [1:0] rsp_request,
   output logic [7:0] rsp_channel,
   output logic       rsp_channel_given
);
   import scpi_pkg::*;

   char_class_type q_item;
   result_type     res;
   logic           q_valid, q_take, res_push, res_full;

   scpi_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_in_char   (req_in_char),
      .req_last_char (req_last_char),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_take        (q_take)
   );

   scpi_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_take     (q_take),
      .out_full   (res_full),
      .out_push   (res_push),
      .out_result (res)
   );

   scpi_rsp_queue u_rsp_queue (
      .clock             (clock),
      .reset             (reset),
      .in_push           (res_push),
      .in_result         (res),
      .in_full           (res_full),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_field_kind    (rsp_field_kind),
      .rsp_out_char      (rsp_out_char),
      .rsp_field_index   (rsp_field_index),
      .rsp_line_done     (rsp_line_done),
      .rsp_status        (rsp_status),
      .rsp_request       (rsp_request),
      .rsp_channel       (rsp_channel),
      .rsp_channel_given (rsp_channel_given)
   );

endmodule
